// ===== design/bnf_pkg.sv =====
package bnf_pkg;

    // Operation codes carried by the func field of an input item.
    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_CHECK   = 2'd1,
        FUNC_INSERT  = 2'd2,
        FUNC_COMPACT = 2'd3
    } t_func;

    localparam int SCORE_BITS    = 16;
    localparam int THR_BITS      = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index is paddr[2]; only index zero exists.
    localparam logic REG_THR = 1'b0;

    localparam logic [THR_BITS-1:0] THR_RESET = 16'h8000;

endpackage

// ===== design/box_nms_filter_top.sv =====
// A check or insert item walks the stored entries until the table ends or it is
// suppressed; a clear goes straight to its result and a compact sweeps the table once.
// Throughput: one item at a time; the entry walk reads one table slot per cycle from the
// box and score memories, so the number of stored entries sets the length of the walk.
// Reset (synchronous, active low) empties the table, sets the threshold to one half and
// drops any pending result; the memory contents are not cleared.
module box_nms_filter_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [bnf_pkg::APB_ADDR_BITS-1:0]       paddr,
    input  logic [bnf_pkg::APB_DATA_BITS-1:0]       pwdata,
    output logic [bnf_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                    pready,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  bnf_pkg::t_func                          i_func,
    input  logic signed [COORD_BITS-1:0]            i_left_x,
    input  logic signed [COORD_BITS-1:0]            i_top_y,
    input  logic signed [COORD_BITS-1:0]            i_right_x,
    input  logic signed [COORD_BITS-1:0]            i_bottom_y,
    input  logic [bnf_pkg::SCORE_BITS-1:0]          i_score,
    input  logic                                    i_respect_score,
    input  logic                                    i_skip_enable,
    input  logic [$clog2(TABLE_DEPTH)-1:0]          i_skip_slot,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_suppressed,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]        o_demoted_count,
    output logic                                    o_inserted,
    output logic                                    o_overflow,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]        o_entry_count
);
    import bnf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = 4 * COORD_BITS;      // one stored box: left, top, right, bottom
    localparam int DW    = COORD_BITS + 2;      // signed overlap extent before clamping
    localparam int WB    = COORD_BITS + 1;      // clamped extent and box side difference
    localparam int AW    = 2 * COORD_BITS + 2;  // signed area and unsigned intersection
    localparam int UW    = 2 * COORD_BITS + 3;  // signed union
    localparam int PW    = 2 * COORD_BITS + 18; // cross-multiplied compare width

    localparam logic [CNT_W-1:0]     DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic signed [DW-1:0] D_ONE   = DW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_COMPACT,
        S_FINISH,
        S_RESULT
    } t_state;

    // Control state
    t_state               r_state;
    logic [THR_BITS-1:0]  r_thr;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_issue;
    logic [CNT_W-1:0]     r_wr_j;
    logic                 r_supp;
    logic [CNT_W-1:0]     r_dem;
    logic                 r_res_ins;
    logic                 r_res_ovf;
    logic                 r_p0_v, r_p1_v, r_p2_v, r_p3_v, r_p4_v;

    // Registered result
    logic                 r_o_valid;
    logic                 r_o_supp;
    logic [CNT_W-1:0]     r_o_dem;
    logic                 r_o_ins;
    logic                 r_o_ovf;
    logic [CNT_W-1:0]     r_o_cnt;

    // Latched candidate
    t_func                      r_func;
    logic signed [COORD_BITS-1:0] r_cl, r_ct, r_cr, r_cb;
    logic signed [WB-1:0]       r_cdx, r_cdy;
    logic signed [AW-1:0]       r_a1;
    logic [SCORE_BITS-1:0]      r_cscore;
    logic                       r_respect;
    logic                       r_skip_en;
    logic [IDX_W-1:0]           r_skip;

    // Walk pipeline payload
    logic [IDX_W-1:0]           r_p0_idx, r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx;
    logic [SCORE_BITS-1:0]      r_p1_sc, r_p2_sc, r_p3_sc, r_p4_sc;
    logic [WB-1:0]              r_p1_w, r_p1_h;
    logic signed [WB-1:0]       r_p1_dx, r_p1_dy;
    logic [AW-1:0]              r_p2_inter, r_p3_inter, r_p4_inter;
    logic signed [AW-1:0]       r_p2_a2;
    logic signed [UW-1:0]       r_p3_uni;
    logic [PW-1:0]              r_p4_rhs;
    logic                       r_p4_upos, r_p4_uzero;

    // Memories and their registered read data
    logic [CW-1:0]              mem_box [TABLE_DEPTH];
    logic [SCORE_BITS-1:0]      mem_sc  [TABLE_DEPTH];
    logic [CW-1:0]              r_bq;
    logic [SCORE_BITS-1:0]      r_sq;

    logic                       in_xfer;
    logic                       cfg_wr;
    logic                       issue_go;
    logic                       skip_hit;
    logic                       pipe_busy;
    logic [IDX_W-1:0]           rd_addr;
    logic [IDX_W-1:0]           wr_addr;
    logic                       box_we, sc_we;
    logic [CW-1:0]              box_wd;
    logic [SCORE_BITS-1:0]      sc_wd;
    logic                       compact_keep;
    logic                       self_zero, do_insert, want_ovf;

    logic signed [COORD_BITS-1:0] q_l, q_t, q_r, q_b;
    logic signed [COORD_BITS-1:0] mn_r, mx_l, mn_b, mx_t;
    logic signed [DW-1:0]       w_raw, h_raw;
    logic [WB-1:0]              w_clip, h_clip;
    logic signed [WB-1:0]       q_dx, q_dy;
    logic signed [AW:0]         inter_s;
    logic signed [UW-1:0]       uni;
    logic [PW-1:0]              lhs;
    logic                       ovl, hit, demote, supp_now;

    // ------------------------------------------------------------------
    // Handshakes and configuration port
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && (paddr[APB_ADDR_BITS-1] == REG_THR);
    assign prdata     = (paddr[APB_ADDR_BITS-1] == REG_THR)
                        ? {{(APB_DATA_BITS-THR_BITS){1'b0}}, r_thr} : '0;

    assign o_out_valid     = r_o_valid;
    assign o_suppressed    = r_o_supp;
    assign o_demoted_count = r_o_dem;
    assign o_inserted      = r_o_ins;
    assign o_overflow      = r_o_ovf;
    assign o_entry_count   = r_o_cnt;

    // ------------------------------------------------------------------
    // Read issue. One slot is read per cycle in both the check walk and the
    // compaction sweep. The candidate's own slot is read but never marked
    // valid, so it drops out of the comparison pipeline.
    // ------------------------------------------------------------------
    assign rd_addr   = r_issue[IDX_W-1:0];
    assign skip_hit  = r_skip_en && (CNT_W'(r_skip) == r_issue);
    assign issue_go  = ((r_state == S_WALK) || (r_state == S_COMPACT))
                       && (r_issue < r_count) && !r_supp && !supp_now;
    assign pipe_busy = r_p0_v || r_p1_v || r_p2_v || r_p3_v || r_p4_v;

    // ------------------------------------------------------------------
    // Stage 1: overlap extents from the stored box and the candidate.
    // The intersection counts one extra pixel per side; areas do not.
    // ------------------------------------------------------------------
    always_comb begin
        q_l    = signed'(r_bq[CW-1 -: COORD_BITS]);
        q_t    = signed'(r_bq[3*COORD_BITS-1 -: COORD_BITS]);
        q_r    = signed'(r_bq[2*COORD_BITS-1 -: COORD_BITS]);
        q_b    = signed'(r_bq[COORD_BITS-1:0]);
        mn_r   = (r_cr < q_r) ? r_cr : q_r;
        mx_l   = (r_cl > q_l) ? r_cl : q_l;
        mn_b   = (r_cb < q_b) ? r_cb : q_b;
        mx_t   = (r_ct > q_t) ? r_ct : q_t;
        w_raw  = DW'(mn_r) - DW'(mx_l) + D_ONE;
        h_raw  = DW'(mn_b) - DW'(mx_t) + D_ONE;
        w_clip = w_raw[DW-1] ? '0 : w_raw[WB-1:0];
        h_clip = h_raw[DW-1] ? '0 : h_raw[WB-1:0];
        q_dx   = WB'(q_r) - WB'(q_l);
        q_dy   = WB'(q_b) - WB'(q_t);
    end

    // Stage 3: union = area(candidate) + area(stored) - intersection.
    always_comb begin
        inter_s = signed'({1'b0, r_p2_inter});
        uni     = UW'(r_a1) + UW'(r_p2_a2) - UW'(inter_s);
    end

    // ------------------------------------------------------------------
    // Decision at the end of the pipeline. A positive union uses the
    // cross-multiplied threshold test; a zero union overlaps when there is
    // any intersection; a negative union overlaps only with no intersection
    // and a zero threshold.
    // ------------------------------------------------------------------
    always_comb begin
        lhs = {r_p4_inter, {THR_BITS{1'b0}}};
        if (r_p4_upos) begin
            ovl = (lhs >= r_p4_rhs);
        end else if (r_p4_uzero) begin
            ovl = (r_p4_inter != '0);
        end else begin
            ovl = (r_p4_inter == '0) && (r_thr == '0);
        end
        hit      = r_p4_v && ovl;
        demote   = hit && r_respect && (r_cscore > r_p4_sc);
        supp_now = hit && !demote;
    end

    // End-of-walk actions. A suppressed candidate zeroes its own slot; a
    // survivor of an insert operation is appended unless the table is full.
    assign self_zero    = r_supp && r_skip_en && (CNT_W'(r_skip) < r_count);
    assign do_insert    = (r_func == FUNC_INSERT) && !r_supp && (r_count < DEPTH_C);
    assign want_ovf     = (r_func == FUNC_INSERT) && !r_supp && (r_count >= DEPTH_C);
    assign compact_keep = r_p0_v && (r_sq != '0);

    // Memory write port selection: demotions during the walk, kept entries
    // during compaction, and the single closing write of a check or an insert.
    always_comb begin
        box_we  = 1'b0;
        sc_we   = 1'b0;
        wr_addr = r_wr_j[IDX_W-1:0];
        box_wd  = r_bq;
        sc_wd   = r_sq;
        case (r_state)
            S_WALK: begin
                if (demote) begin
                    sc_we   = 1'b1;
                    wr_addr = r_p4_idx;
                    sc_wd   = '0;
                end
            end
            S_COMPACT: begin
                if (compact_keep) begin
                    box_we = 1'b1;
                    sc_we  = 1'b1;
                end
            end
            S_FINISH: begin
                if (self_zero) begin
                    sc_we   = 1'b1;
                    wr_addr = r_skip;
                    sc_wd   = '0;
                end else if (do_insert) begin
                    box_we  = 1'b1;
                    sc_we   = 1'b1;
                    wr_addr = r_count[IDX_W-1:0];
                    box_wd  = {r_cl, r_ct, r_cr, r_cb};
                    sc_wd   = r_cscore;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Box and score memories with registered read data. Within a walk a
    // demotion write always targets an earlier slot than the slot being
    // read, and a compaction write never passes the read pointer, so no
    // forwarding is needed.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (box_we) begin
            mem_box[wr_addr] <= box_wd;
        end
        r_bq <= mem_box[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            mem_sc[wr_addr] <= sc_wd;
        end
        r_sq <= mem_sc[rd_addr];
    end

    // ------------------------------------------------------------------
    // Candidate latch and comparison pipeline datapath.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func    <= i_func;
            r_cl      <= i_left_x;
            r_ct      <= i_top_y;
            r_cr      <= i_right_x;
            r_cb      <= i_bottom_y;
            r_cdx     <= WB'(i_right_x) - WB'(i_left_x);
            r_cdy     <= WB'(i_bottom_y) - WB'(i_top_y);
            r_cscore  <= i_score;
            r_respect <= i_respect_score;
            r_skip_en <= i_skip_enable;
            r_skip    <= i_skip_slot;
        end
        // The candidate area is registered from the latched sides, well before
        // the first entry reaches stage 3.
        r_a1 <= AW'(r_cdx) * AW'(r_cdy);

        r_p0_idx <= rd_addr;

        r_p1_idx <= r_p0_idx;
        r_p1_sc  <= r_sq;
        r_p1_w   <= w_clip;
        r_p1_h   <= h_clip;
        r_p1_dx  <= q_dx;
        r_p1_dy  <= q_dy;

        r_p2_idx   <= r_p1_idx;
        r_p2_sc    <= r_p1_sc;
        r_p2_inter <= AW'(r_p1_w) * AW'(r_p1_h);
        r_p2_a2    <= AW'(r_p1_dx) * AW'(r_p1_dy);

        r_p3_idx   <= r_p2_idx;
        r_p3_sc    <= r_p2_sc;
        r_p3_inter <= r_p2_inter;
        r_p3_uni   <= uni;

        r_p4_idx   <= r_p3_idx;
        r_p4_sc    <= r_p3_sc;
        r_p4_inter <= r_p3_inter;
        r_p4_rhs   <= PW'(r_thr) * PW'(r_p3_uni[UW-2:0]);
        r_p4_upos  <= !r_p3_uni[UW-1] && (r_p3_uni != '0);
        r_p4_uzero <= (r_p3_uni == '0);
    end

    // ------------------------------------------------------------------
    // Sequencer: state, counters, pipeline valid bits and registered result.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thr     <= THR_RESET;
            r_count   <= '0;
            r_issue   <= '0;
            r_wr_j    <= '0;
            r_supp    <= 1'b0;
            r_dem     <= '0;
            r_res_ins <= 1'b0;
            r_res_ovf <= 1'b0;
            r_p0_v    <= 1'b0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_p3_v    <= 1'b0;
            r_p4_v    <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_supp  <= 1'b0;
            r_o_dem   <= '0;
            r_o_ins   <= 1'b0;
            r_o_ovf   <= 1'b0;
            r_o_cnt   <= '0;
        end else begin
            if (cfg_wr) begin
                r_thr <= pwdata[THR_BITS-1:0];
            end

            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            // A suppression flushes entries that were read past it.
            r_p0_v <= issue_go && !((r_state == S_WALK) && skip_hit);
            r_p1_v <= r_p0_v && (r_state == S_WALK) && !supp_now;
            r_p2_v <= r_p1_v && !supp_now;
            r_p3_v <= r_p2_v && !supp_now;
            r_p4_v <= r_p3_v && !supp_now;

            if (issue_go) begin
                r_issue <= r_issue + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_issue   <= '0;
                        r_wr_j    <= '0;
                        r_supp    <= 1'b0;
                        r_dem     <= '0;
                        r_res_ins <= 1'b0;
                        r_res_ovf <= 1'b0;
                        case (i_func)
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_RESULT;
                            end
                            FUNC_COMPACT: begin
                                r_state <= S_COMPACT;
                            end
                            default: begin
                                r_state <= S_WALK;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (supp_now) begin
                        r_supp <= 1'b1;
                    end
                    if (demote && (r_p4_sc != '0)) begin
                        r_dem <= r_dem + 1'b1;
                    end
                    if (((r_issue >= r_count) || r_supp) && !pipe_busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_COMPACT: begin
                    if (compact_keep) begin
                        r_wr_j <= r_wr_j + 1'b1;
                    end
                    if ((r_issue >= r_count) && !r_p0_v) begin
                        r_count <= r_wr_j;
                        r_state <= S_RESULT;
                    end
                end
                S_FINISH: begin
                    r_res_ins <= do_insert;
                    r_res_ovf <= want_ovf;
                    if (do_insert) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // The result register frees up when its transfer completes.
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_supp  <= r_supp;
                        r_o_dem   <= r_dem;
                        r_o_ins   <= r_res_ins;
                        r_o_ovf   <= r_res_ovf;
                        r_o_cnt   <= r_count;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/bnf_checker.sv =====
module bnf_checker #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_suppressed,
    input logic [$clog2(TABLE_DEPTH+1)-1:0]   o_demoted_count,
    input logic                               o_inserted,
    input logic                               o_overflow,
    input logic [$clog2(TABLE_DEPTH+1)-1:0]   o_entry_count
);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam int COORD_W = COORD_BITS;

    // A stalled result stays put until its transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_suppressed)
            && $stable(o_demoted_count) && $stable(o_inserted)
            && $stable(o_overflow) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // A suppressed candidate is never inserted and never flags overflow.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_suppressed |-> !o_inserted && !o_overflow)
        else $error("suppressed candidate inserted or overflowed");

    // An insertion leaves at least one entry and excludes overflow.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inserted |-> !o_overflow && (o_entry_count != '0))
        else $error("insert with empty table or overflow");

    // Overflow is only reported with a full table, and the count never exceeds depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= DEPTH_C) && (o_demoted_count <= DEPTH_C)
            && (!o_overflow || (o_entry_count == DEPTH_C)) && (COORD_W > 0))
        else $error("entry count or overflow inconsistent");

endmodule

bind box_nms_filter_top bnf_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS)
) u_bnf_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bnf_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int COORD_BITS  = 12;
    localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);

    // Smallest and largest coordinate that a signed field can carry.
    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

    // The threshold register is index zero, so its byte address is zero.
    localparam logic [APB_ADDR_BITS-1:0] THR_ADDR = {REG_THR, 2'b00};

    // Random items per threshold setting. Each random test runs three settings.
    localparam int SEG_ITEMS = 180;

    // The watchdog ends the run after this many cycles without any transfer.
    // It lies well above the slowest item and the deliberate output stall,
    // so this leaves a wide margin.
    localparam int QUIET_LIMIT = 3000;

    // A candidate box as it travels on the input ports. The corners are kept
    // as raw bit patterns and read back as signed values where needed.
    typedef struct packed {
        logic [COORD_BITS-1:0] left_x;
        logic [COORD_BITS-1:0] top_y;
        logic [COORD_BITS-1:0] right_x;
        logic [COORD_BITS-1:0] bottom_y;
    } t_box;

    typedef struct packed {
        t_func                 func;
        t_box                  box;
        logic [SCORE_BITS-1:0] score;
        logic                  respect;
        logic                  skip_en;
        logic [SLOT_BITS-1:0]  skip_slot;
    } t_candidate;

    // The verdict that the block returns for every candidate.
    typedef struct packed {
        logic                  suppressed;
        logic [COUNT_BITS-1:0] demoted_count;
        logic                  inserted;
        logic                  overflow;
        logic [COUNT_BITS-1:0] entry_count;
    } t_verdict;

    // Clock, reset and every input of the block start at known values.
    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // The whole payload of the input channel is one variable, so a new item
    // is put on the ports by a single nonblocking assignment.
    t_candidate offered   = '0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       out_ready = 1'b0;

    logic                  res_suppressed;
    logic [COUNT_BITS-1:0] res_demoted_count;
    logic                  res_inserted;
    logic                  res_overflow;
    logic [COUNT_BITS-1:0] res_entry_count;

    // Our own copy of the box table, its scores, its fill level and the
    // threshold, advanced once per accepted candidate.
    t_box                  tbl_box[TABLE_DEPTH];
    logic [SCORE_BITS-1:0] tbl_score[TABLE_DEPTH];
    int                    tbl_count = 0;
    logic [THR_BITS-1:0]   thr_model = THR_RESET;

    // Verdicts predicted at input transfers and not yet seen at the output.
    t_verdict expected_verdicts[$];
    t_verdict want;

    int n_errors      = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;

    box_nms_filter_top #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (offered.func),
        .i_left_x       (offered.box.left_x),
        .i_top_y        (offered.box.top_y),
        .i_right_x      (offered.box.right_x),
        .i_bottom_y     (offered.box.bottom_y),
        .i_score        (offered.score),
        .i_respect_score(offered.respect),
        .i_skip_enable  (offered.skip_en),
        .i_skip_slot    (offered.skip_slot),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_suppressed   (res_suppressed),
        .o_demoted_count(res_demoted_count),
        .o_inserted     (res_inserted),
        .o_overflow     (res_overflow),
        .o_entry_count  (res_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // IoU test of a candidate against one stored box. The intersection gets
    // one extra pixel per side while the areas do not, so degenerate and
    // inverted boxes can give a union of zero or below. A positive union uses
    // the cross-multiplied comparison; a zero union overlaps only when the
    // boxes share pixels; a negative union overlaps only when they share none
    // and the threshold is zero.
    function automatic bit iou_reaches_threshold(t_box cand_box, t_box kept_box);
        longint l1, t1, r1, b1, l2, t2, r2, b2;
        longint w, h, inter, area_c, area_k, uni;
        l1 = $signed(cand_box.left_x);
        t1 = $signed(cand_box.top_y);
        r1 = $signed(cand_box.right_x);
        b1 = $signed(cand_box.bottom_y);
        l2 = $signed(kept_box.left_x);
        t2 = $signed(kept_box.top_y);
        r2 = $signed(kept_box.right_x);
        b2 = $signed(kept_box.bottom_y);
        w = ((r1 < r2) ? r1 : r2) - ((l1 > l2) ? l1 : l2) + 1;
        h = ((b1 < b2) ? b1 : b2) - ((t1 > t2) ? t1 : t2) + 1;
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        inter  = w * h;
        area_c = (r1 - l1) * (b1 - t1);
        area_k = (r2 - l2) * (b2 - t2);
        uni    = area_c + area_k - inter;
        if (uni > 0) return inter * 65536 >= longint'(thr_model) * uni;
        if (uni == 0) return inter > 0;
        return inter == 0 && thr_model == 0;
    endfunction

    // Applies one candidate to the table copy and returns the verdict that
    // the block must produce for it.
    function automatic t_verdict predict_nms(t_candidate c);
        t_verdict v;
        int       keep;
        v = '0;
        if (c.func == FUNC_CLEAR) begin
            tbl_count = 0;
        end else if (c.func == FUNC_COMPACT) begin
            keep = 0;
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_score[i] != 0) begin
                    tbl_box[keep]   = tbl_box[i];
                    tbl_score[keep] = tbl_score[i];
                    keep++;
                end
            end
            tbl_count = keep;
        end else begin
            // Walk the table in slot order. A demotion keeps the walk going,
            // a loss ends it.
            for (int i = 0; i < tbl_count; i++) begin
                if (c.skip_en && i == c.skip_slot) continue;
                if (!iou_reaches_threshold(c.box, tbl_box[i])) continue;
                if (c.respect && c.score > tbl_score[i]) begin
                    if (tbl_score[i] != 0) v.demoted_count = v.demoted_count + 1'b1;
                    tbl_score[i] = '0;
                end else begin
                    v.suppressed = 1'b1;
                    break;
                end
            end
            // A suppressed candidate that is itself stored loses its score.
            if (v.suppressed && c.skip_en && c.skip_slot < tbl_count)
                tbl_score[c.skip_slot] = '0;
            if (c.func == FUNC_INSERT && !v.suppressed) begin
                if (tbl_count >= TABLE_DEPTH) begin
                    v.overflow = 1'b1;
                end else begin
                    tbl_box[tbl_count]   = c.box;
                    tbl_score[tbl_count] = c.score;
                    tbl_count++;
                    v.inserted = 1'b1;
                end
            end
        end
        v.entry_count = tbl_count;
        return v;
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_val,
                                          logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            n_errors++;
        end
    endfunction

    // Scoreboard. Output transfers are checked before input transfers are
    // predicted, so a verdict leaving at the same edge as a new item arrives
    // is matched against the older expectation. All values are sampled at
    // the edge, before anything driven at that edge takes effect.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("verdict transfer with no candidate outstanding");
                    n_errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    compare_field("suppressed", want.suppressed, res_suppressed);
                    compare_field("demoted_count", want.demoted_count, res_demoted_count);
                    compare_field("inserted", want.inserted, res_inserted);
                    compare_field("overflow", want.overflow, res_overflow);
                    compare_field("entry_count", want.entry_count, res_entry_count);
                end
            end
            if (in_valid && in_ready)
                expected_verdicts.push_back(predict_nms(offered));
        end
    end

    // Output side. A pending stall request holds ready low for its full
    // length; otherwise ready drops at random at the current idle rate.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Any transfer on either channel or the register port counts as progress.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offers one candidate and returns at the edge of its transfer. When the
    // sender idles, valid is dropped first and raised again after a random wait;
    // otherwise valid stays high straight into the next item.
    task automatic offer_candidate(input t_candidate c);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        offered  <= c;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Stops offering and waits until every verdict has been transferred.
    task automatic wait_all_verdicts();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_verdicts.size() != 0);
    endtask

    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reads the threshold back and compares it with the value we expect.
    task automatic check_threshold_readback();
        logic [APB_DATA_BITS-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THR_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        compare_field("overlap_threshold", thr_model, data[THR_BITS-1:0]);
    endtask

    // The block must be idle, so every outstanding verdict is collected first.
    task automatic program_threshold(input logic [THR_BITS-1:0] thr);
        wait_all_verdicts();
        apb_write(THR_ADDR, APB_DATA_BITS'(thr));
        thr_model = thr;
        check_threshold_readback();
    endtask

    function automatic t_candidate box_item(t_func f, int l, int t, int r, int b,
                                            int unsigned s, bit resp, bit skip_en,
                                            int unsigned slot);
        t_candidate c;
        c.func         = f;
        c.box.left_x   = l[COORD_BITS-1:0];
        c.box.top_y    = t[COORD_BITS-1:0];
        c.box.right_x  = r[COORD_BITS-1:0];
        c.box.bottom_y = b[COORD_BITS-1:0];
        c.score        = s[SCORE_BITS-1:0];
        c.respect      = resp;
        c.skip_en      = skip_en;
        c.skip_slot    = slot[SLOT_BITS-1:0];
        return c;
    endfunction

    // Moves a stored corner by a few pixels, saturating at the field range.
    function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] v);
        int moved;
        moved = $signed(v) + int'($urandom_range(8)) - 4;
        if (moved < COORD_MIN) moved = COORD_MIN;
        if (moved > COORD_MAX) moved = COORD_MAX;
        return moved[COORD_BITS-1:0];
    endfunction

    // Random candidates are mostly checks and inserts. A good share are
    // jittered copies of stored boxes so that overlaps, demotions and
    // suppressions are frequent; the rest are small fresh boxes and fully
    // random corners, which also give inverted and degenerate shapes.
    function automatic t_candidate draw_candidate();
        t_candidate c;
        int         pick, x, y, src;
        c    = '0;
        pick = $urandom_range(99);
        if (pick < 3)       c.func = FUNC_CLEAR;
        else if (pick < 9)  c.func = FUNC_COMPACT;
        else if (pick < 40) c.func = FUNC_CHECK;
        else                c.func = FUNC_INSERT;
        pick = $urandom_range(99);
        if (pick < 15) begin
            c.box.left_x   = $urandom;
            c.box.top_y    = $urandom;
            c.box.right_x  = $urandom;
            c.box.bottom_y = $urandom;
        end else if (pick < 55 && tbl_count != 0) begin
            src = $urandom_range(tbl_count - 1);
            c.box.left_x   = nudge(tbl_box[src].left_x);
            c.box.top_y    = nudge(tbl_box[src].top_y);
            c.box.right_x  = nudge(tbl_box[src].right_x);
            c.box.bottom_y = nudge(tbl_box[src].bottom_y);
        end else begin
            x = int'($urandom_range(COORD_MAX - COORD_MIN - 64)) + COORD_MIN;
            y = int'($urandom_range(COORD_MAX - COORD_MIN - 64)) + COORD_MIN;
            c.box.left_x   = x[COORD_BITS-1:0];
            c.box.top_y    = y[COORD_BITS-1:0];
            x = x + int'($urandom_range(63));
            y = y + int'($urandom_range(63));
            c.box.right_x  = x[COORD_BITS-1:0];
            c.box.bottom_y = y[COORD_BITS-1:0];
        end
        pick = $urandom_range(99);
        if (pick < 10)      c.score = '0;
        else if (pick < 20) c.score = '1;
        else                c.score = $urandom;
        c.respect = $urandom_range(1);
        c.skip_en = ($urandom_range(99) < 30);
        if (tbl_count != 0 && $urandom_range(99) < 70)
            c.skip_slot = $urandom_range(tbl_count - 1);
        else
            c.skip_slot = $urandom_range(TABLE_DEPTH - 1);
        return c;
    endfunction

    // Hand-built sequence through every operation and every corner of the
    // walk: equal scores, demotion of an already zero entry, skipping the
    // candidate's own slot, a suppressed self entry, an out-of-range self
    // slot, coordinate extremes, a zero union, a negative union with a zero
    // threshold, and the strictest threshold.
    task automatic test_directed_cases();
        send_idle_pct = 24;
        recv_idle_pct = 45;
        offer_candidate(box_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_candidate(box_item(FUNC_INSERT, 0, 0, 9, 9, 100, 0, 0, 0));
        offer_candidate(box_item(FUNC_CHECK, 0, 0, 9, 9, 50, 0, 0, 0));
        offer_candidate(box_item(FUNC_INSERT, 100, 100, 109, 109, 200, 0, 0, 0));
        // A higher score with respect set demotes the first box and survives.
        offer_candidate(box_item(FUNC_INSERT, 1, 1, 10, 10, 300, 1, 0, 0));
        // This one meets the already demoted box again, which is not counted.
        offer_candidate(box_item(FUNC_INSERT, 0, 0, 10, 10, 400, 1, 0, 0));
        // An equal score does not demote, so the candidate loses.
        offer_candidate(box_item(FUNC_CHECK, 1, 1, 10, 10, 400, 1, 0, 0));
        offer_candidate(box_item(FUNC_COMPACT, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_candidate(box_item(FUNC_CHECK, 100, 100, 109, 109, 10, 0, 1, 0));
        // Suppressed while naming slot zero as its own, which zeroes slot zero.
        offer_candidate(box_item(FUNC_CHECK, 0, 0, 9, 9, 10, 0, 1, 0));
        offer_candidate(box_item(FUNC_COMPACT, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_candidate(box_item(FUNC_CHECK, 0, 0, 10, 10, 0, 0, 1, 15));
        offer_candidate(box_item(FUNC_INSERT, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                 65535, 0, 0, 0));
        offer_candidate(box_item(FUNC_INSERT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                 0, 0, 0, 0));
        offer_candidate(box_item(FUNC_INSERT, 300, 300, 302, 301, 500, 0, 0, 0));
        // A flat box against the one above gives a union of exactly zero.
        offer_candidate(box_item(FUNC_CHECK, 300, 300, 300, 301, 100, 0, 0, 0));
        program_threshold('0);
        // An inverted box against a point box gives a negative union.
        offer_candidate(box_item(FUNC_CHECK, 500, 500, 490, 510, 100, 0, 0, 0));
        offer_candidate(box_item(FUNC_INSERT, 600, 600, 610, 610, 1, 1, 0, 0));
        program_threshold('1);
        offer_candidate(box_item(FUNC_CHECK, 0, 0, 10, 10, 10, 0, 0, 0));
        offer_candidate(box_item(FUNC_CHECK, 0, 0, 10, 9, 10, 0, 0, 0));
        // A survivor is appended even when it names a slot of its own.
        offer_candidate(box_item(FUNC_INSERT, 800, 800, 810, 810, 7, 0, 1, 0));
        program_threshold(THR_RESET);
    endtask

    // Fills every slot with disjoint boxes along the diagonal, from the
    // lowest corner to the highest, then tries one more insert and one check.
    task automatic test_table_full();
        int lo, hi;
        offer_candidate(box_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            lo = COORD_MIN + 256 * k;
            hi = (k == TABLE_DEPTH - 1) ? COORD_MAX : lo + 200;
            offer_candidate(box_item(FUNC_INSERT, lo, lo, hi, hi, 1000 + k, 0, 0, 0));
        end
        offer_candidate(box_item(FUNC_INSERT, COORD_MIN, COORD_MAX - 40, COORD_MIN + 8,
                                 COORD_MAX, 9, 0, 0, 0));
        offer_candidate(box_item(FUNC_CHECK, 0, 0, 4, 4, 9, 0, 0, 0));
    endtask

    // The receiver holds ready low through a requested stall while the sender keeps
    // offering, so the block backs up and stops accepting input.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left   <= 400;
        repeat (12) offer_candidate(draw_candidate());
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [THR_BITS-1:0] thr_first,
                                       input logic [THR_BITS-1:0] thr_second,
                                       input logic [THR_BITS-1:0] thr_third);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        program_threshold(thr_first);
        repeat (SEG_ITEMS) offer_candidate(draw_candidate());
        program_threshold(thr_second);
        repeat (SEG_ITEMS) offer_candidate(draw_candidate());
        program_threshold(thr_third);
        repeat (SEG_ITEMS) offer_candidate(draw_candidate());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The threshold must come out of reset at one half.
        check_threshold_readback();
        test_directed_cases();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(24, 45, THR_RESET, '1, '0);
        test_random_traffic(45, 24, 16'd1, 16'h4000, $urandom);
        test_random_traffic(0, 0, 16'hC000, $urandom, 16'd40000);

        // Collect the last verdicts, then give any stray transfer time to
        // show up before the verdict on the run.
        wait_all_verdicts();
        repeat (40) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bnf_pkg.sv
design/box_nms_filter_top.sv
design/bnf_checker.sv
bench/testbench.sv
